// ===== hdl/azimuth_sigmoid_gain_assert.svh =====
// Assertion macros for the azimuth sigmoid gain block.
// Used by azimuth_sigmoid_gain.sv; expects signals clk and rst_n in scope.
`ifndef AZIMUTH_SIGMOID_GAIN_ASSERT_SVH
`define AZIMUTH_SIGMOID_GAIN_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a condition in the same cycle as its cause
`define ASG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("azimuth_sigmoid_gain: assertion failed");

// Check a condition in the cycle after its cause
`define ASG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("azimuth_sigmoid_gain: assertion failed");

`else

`define ASG_ASSERT_IMP(lbl, ante, cons)
`define ASG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/asg_pkg.sv =====
// Shared types, constants and the sigmoid lookup tables of the azimuth gain block.
// No dependencies; imported by asg_regs, asg_sigmoid, azimuth_sigmoid_gain and the testbench.
package asg_pkg;

  // Table shape and sigmoid precision
  localparam int SIG_DEPTH = 256;
  localparam int FRAC_BITS = 16;
  localparam int DB        = $clog2(SIG_DEPTH);
  localparam int TW        = FRAC_BITS + 1;
  localparam int ARG_BITS  = 28;
  localparam int FW        = ARG_BITS - DB;

  localparam logic [ARG_BITS:0] ARG_CLIP = {1'b1, {ARG_BITS{1'b0}}};
  localparam logic [TW-1:0]     SIG_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [16:0]       GAIN_ONE = 17'h10000;

  // APB register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SLOPE_A     = 3'd0;
  localparam logic [2:0] REG_POSITION_A  = 3'd1;
  localparam logic [2:0] REG_FLOOR_A     = 3'd2;
  localparam logic [2:0] REG_INV_RANGE_A = 3'd3;
  localparam logic [2:0] REG_SLOPE_B     = 3'd4;
  localparam logic [2:0] REG_POSITION_B  = 3'd5;
  localparam logic [2:0] REG_FLOOR_B     = 3'd6;
  localparam logic [2:0] REG_INV_RANGE_B = 3'd7;

  typedef struct packed {
    logic [15:0] slope_a;
    logic [15:0] position_a;
    logic [15:0] floor_a;
    logic [23:0] inv_range_a;
    logic [15:0] slope_b;
    logic [15:0] position_b;
    logic [15:0] floor_b;
    logic [23:0] inv_range_b;
  } cfg_t;

  // Word entering the sigmoid pipeline
  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [15:0] mag;
    logic [15:0] slope;
    logic        tag;
  } sig_in_t;

  // Word leaving the sigmoid pipeline
  typedef struct packed {
    logic        vld;
    logic [16:0] s16;
    logic        tag;
  } sig_out_t;

  typedef logic [TW-1:0] rom_t  [0:SIG_DEPTH];
  typedef logic [TW-1:0] even_t [0:SIG_DEPTH/2];
  typedef logic [TW-1:0] odd_t  [0:SIG_DEPTH/2-1];

  // Long division by shift and subtract, used only while building the table
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the logistic table at elaboration: e^(-16/depth) by series, then powers
  function automatic rom_t build_rom();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ratio;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    rom_t        t;
    term = 64'd1 << 31;
    sum  = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      term = udiv(term * 64'd16, 64'(SIG_DEPTH) * 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    ratio = sum;
    p     = 64'd1 << 31;
    num   = 64'd1 << (FRAC_BITS + 31);
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      den  = (64'd1 << 31) + p;
      t[i] = TW'(udiv(num + (den >> 1), den));
      p    = (p * ratio) >> 31;
    end
    return t;
  endfunction

  // Even entries of the table
  function automatic even_t build_even(rom_t t);
    even_t e;
    for (int i = 0; i <= SIG_DEPTH / 2; i++) begin
      e[i] = t[2 * i];
    end
    return e;
  endfunction

  // Odd entries of the table
  function automatic odd_t build_odd(rom_t t);
    odd_t o;
    for (int i = 0; i < SIG_DEPTH / 2; i++) begin
      o[i] = t[2 * i + 1];
    end
    return o;
  endfunction

  localparam rom_t  SIG_ROM  = build_rom();
  localparam even_t SIG_EVEN = build_even(SIG_ROM);
  localparam odd_t  SIG_ODD  = build_odd(SIG_ROM);

endpackage

// ===== hdl/azimuth_sigmoid_gain.sv =====
// Top level of the azimuth sigmoid gain block: input stage, sigmoid pipeline, gain stages.
// Depends on asg_pkg, asg_regs, asg_sigmoid and azimuth_sigmoid_gain_assert.svh.
//
// Usage:
//   Drive in_azimuth_turn (Q0.16 turn) and raise start; a word is taken at each
//   rising edge with start high and busy low. busy is always low, so one word can
//   enter every cycle and the block runs fully pipelined at one word per cycle.
//   Each word gives one result: out_valid is high for one cycle with out_gain
//   (Q1.16, 0..1) and out_used_curve_b. Results leave in input order. The
//   receiver cannot stall; results are not held.
//   Each word passes through eight register stages: input select, slope multiply,
//   table read, interpolation multiply, Q1.16 conversion, floor subtract,
//   range multiply, round and saturate.
//   Configuration goes through the APB port (psel, penable, pwrite, paddr, pwdata,
//   prdata, pready); register i lies at byte address 4*i, pready is always high.
//   Write configuration only when no word is in flight.
//   Synchronous active-low reset clears the pipeline valid bits and loads the
//   register defaults; the sigmoid table is a constant and needs no fill.
`include "azimuth_sigmoid_gain_assert.svh"

module azimuth_sigmoid_gain
  import asg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       in_azimuth_turn,
  // Result channel
  output logic              out_valid,
  output logic [16:0]       out_gain,
  output logic              out_used_curve_b,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PIPE_LAT = 8;

  cfg_t     cfg;
  sig_in_t  sin;
  sig_out_t sout;

  logic accept;

  // Stage 0 registers
  logic        v0_r;
  logic        neg0_r, neg0_nxt;
  logic [15:0] mag0_r, mag0_nxt;
  logic [15:0] slope0_r, slope0_nxt;
  logic        tag0_r, tag0_nxt;
  logic [15:0] u, pos;

  // Stage E, F and output registers
  logic        ve_r, vf_r, out_valid_r;
  logic [16:0] dif_r, dif_nxt;
  logic        pos_e_r, pos_e_nxt, pos_f_r;
  logic [23:0] inv_e_r, inv_e_nxt;
  logic        tag_e_r, tag_f_r, tag_o_r;
  logic [40:0] gp_r, gp_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic [15:0] flr;
  logic [41:0] g_rnd;
  logic [25:0] g_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  asg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 0: pick the curve, fold the second half turn, take distance to midpoint
  always_comb begin
    tag0_nxt   = in_azimuth_turn[15];
    u          = tag0_nxt ? (16'd0 - in_azimuth_turn) : in_azimuth_turn;
    pos        = tag0_nxt ? cfg.position_b : cfg.position_a;
    slope0_nxt = tag0_nxt ? cfg.slope_b : cfg.slope_a;
    neg0_nxt   = u < pos;
    mag0_nxt   = neg0_nxt ? (pos - u) : (u - pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    neg0_r   <= neg0_nxt;
    mag0_r   <= mag0_nxt;
    slope0_r <= slope0_nxt;
    tag0_r   <= tag0_nxt;
  end

  assign sin.vld   = v0_r;
  assign sin.neg   = neg0_r;
  assign sin.mag   = mag0_r;
  assign sin.slope = slope0_r;
  assign sin.tag   = tag0_r;

  asg_sigmoid u_sigmoid (
    .clk   (clk),
    .rst_n (rst_n),
    .sin   (sin),
    .sout  (sout)
  );

  // Stage E: subtract the curve floor
  always_comb begin
    flr       = sout.tag ? cfg.floor_b : cfg.floor_a;
    inv_e_nxt = sout.tag ? cfg.inv_range_b : cfg.inv_range_a;
    pos_e_nxt = sout.s16 > 17'(flr);
    dif_nxt   = sout.s16 - 17'(flr);
  end

  // Stage F: scale by the reciprocal range
  assign gp_nxt = 41'(dif_r) * 41'(inv_e_r);

  // Output stage: round half up, saturate to one, zero at or below the floor
  always_comb begin
    g_rnd = 42'(gp_r) + 42'd32768;
    g_q   = g_rnd[41:16];
    if (!pos_f_r) begin
      gain_nxt = 17'd0;
    end else if (g_q > 26'(GAIN_ONE)) begin
      gain_nxt = GAIN_ONE;
    end else begin
      gain_nxt = g_q[16:0];
    end
  end

  // Advance the valid bits of the gain stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ve_r        <= sout.vld;
      vf_r        <= ve_r;
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    dif_r   <= dif_nxt;
    pos_e_r <= pos_e_nxt;
    inv_e_r <= inv_e_nxt;
    tag_e_r <= sout.tag;
    gp_r    <= gp_nxt;
    pos_f_r <= pos_e_r;
    tag_f_r <= tag_e_r;
    gain_r  <= gain_nxt;
    tag_o_r <= tag_f_r;
  end

  assign out_valid        = out_valid_r;
  assign out_gain         = gain_r;
  assign out_used_curve_b = tag_o_r;

  // Taken word enters stage 0
  `ASG_ASSERT_NXT(a_accept_enters, accept, v0_r)
  // Every result comes from a word taken a fixed latency earlier
  `ASG_ASSERT_IMP(a_fixed_latency, out_valid, $past(accept, PIPE_LAT))
  // Curve flag follows its word through the pipeline
  `ASG_ASSERT_IMP(a_curve_tag, out_valid, out_used_curve_b == $past(in_azimuth_turn[15], PIPE_LAT))
  // Gain never exceeds one
  `ASG_ASSERT_IMP(a_gain_range, out_valid, out_gain <= GAIN_ONE)

endmodule

// ===== hdl/asg_regs.sv =====
// APB configuration registers of the azimuth gain block.
// Depends on asg_pkg for the register map and the cfg_t bundle.
module asg_regs
  import asg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  // Write the addressed register, drop bits above its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slope_a     <= 16'd7680;
      cfg_r.position_a  <= 16'd26214;
      cfg_r.floor_a     <= 16'd4588;
      cfg_r.inv_range_a <= 24'd71939;
      cfg_r.slope_b     <= 16'd3584;
      cfg_r.position_b  <= 16'd8520;
      cfg_r.floor_b     <= 16'd0;
      cfg_r.inv_range_b <= 24'd66265;
    end else if (wr_en) begin
      case (idx)
        REG_SLOPE_A:     cfg_r.slope_a     <= pwdata[15:0];
        REG_POSITION_A:  cfg_r.position_a  <= pwdata[15:0];
        REG_FLOOR_A:     cfg_r.floor_a     <= pwdata[15:0];
        REG_INV_RANGE_A: cfg_r.inv_range_a <= pwdata[23:0];
        REG_SLOPE_B:     cfg_r.slope_b     <= pwdata[15:0];
        REG_POSITION_B:  cfg_r.position_b  <= pwdata[15:0];
        REG_FLOOR_B:     cfg_r.floor_b     <= pwdata[15:0];
        REG_INV_RANGE_B: cfg_r.inv_range_b <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_SLOPE_A:     prdata = {16'd0, cfg_r.slope_a};
      REG_POSITION_A:  prdata = {16'd0, cfg_r.position_a};
      REG_FLOOR_A:     prdata = {16'd0, cfg_r.floor_a};
      REG_INV_RANGE_A: prdata = {8'd0, cfg_r.inv_range_a};
      REG_SLOPE_B:     prdata = {16'd0, cfg_r.slope_b};
      REG_POSITION_B:  prdata = {16'd0, cfg_r.position_b};
      REG_FLOOR_B:     prdata = {16'd0, cfg_r.floor_b};
      REG_INV_RANGE_B: prdata = {8'd0, cfg_r.inv_range_b};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/asg_sigmoid.sv =====
// Four-stage pipelined logistic function with table lookup and interpolation.
// Depends on asg_pkg for the split sigmoid table and the sig_in_t/sig_out_t words.
module asg_sigmoid
  import asg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sig_in_t  sin,
  output sig_out_t sout
);

  localparam int SH_R = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SW   = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int RND  = (1 << SH_R) >> 1;

  // Valid bits of the four stages
  logic [3:0] vld_r;
  logic [3:0] vld_nxt;

  // Stage A: argument magnitude
  logic [31:0]   m_r, m_nxt;
  logic          neg_a_r, tag_a_r;
  // Stage B: table pair and fraction
  logic [TW-1:0] lo_b_r, hi_b_r;
  logic [FW-1:0] fm_b_r;
  logic          neg_b_r, tag_b_r;
  // Stage C: interpolation product
  logic [TW+FW-1:0] prod_r, prod_nxt;
  logic [TW-1:0]    lo_c_r;
  logic             neg_c_r, tag_c_r;
  // Stage D: Q1.16 sigmoid
  logic [16:0]   s16_r, s16_nxt;
  logic          tag_d_r;

  logic [ARG_BITS:0] m_c;
  logic [DB:0]       idx;
  logic [DB+1:0]     e_sum;
  logic [DB-1:0]     e_addr;
  logic [DB-2:0]     o_addr;
  logic [TW-1:0]     e_val, o_val, lo_nxt, hi_nxt;
  logic [FW-1:0]     fm_nxt;
  logic [TW-1:0]     diff, s_i, s_c;
  logic [SW-1:0]     s_w;

  assign vld_nxt = {vld_r[2:0], sin.vld};

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage A: slope times distance
  assign m_nxt = 32'(sin.slope) * 32'(sin.mag);

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    neg_a_r <= sin.neg;
    tag_a_r <= sin.tag;
  end

  // Stage B: clip, split into index and fraction, read both neighbors
  always_comb begin
    m_c    = (m_r > 32'(ARG_CLIP)) ? ARG_CLIP : m_r[ARG_BITS:0];
    idx    = m_c[ARG_BITS:ARG_BITS-DB];
    fm_nxt = m_c[FW-1:0];
    e_sum  = {1'b0, idx} + (DB+2)'(1);
    e_addr = e_sum[DB:1];
    o_addr = idx[DB-1:1];
    e_val  = SIG_EVEN[e_addr];
    o_val  = SIG_ODD[o_addr];
    lo_nxt = idx[0] ? o_val : e_val;
    hi_nxt = idx[0] ? e_val : o_val;
  end

  always_ff @(posedge clk) begin
    lo_b_r  <= lo_nxt;
    hi_b_r  <= hi_nxt;
    fm_b_r  <= fm_nxt;
    neg_b_r <= neg_a_r;
    tag_b_r <= tag_a_r;
  end

  // Stage C: scale the step between neighbors by the fraction
  assign diff     = hi_b_r - lo_b_r;
  assign prod_nxt = (TW+FW)'(diff) * (TW+FW)'(fm_b_r);

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    lo_c_r  <= lo_b_r;
    neg_c_r <= neg_b_r;
    tag_c_r <= tag_b_r;
  end

  // Stage D: add, mirror for negative arguments, bring to Q1.16
  always_comb begin
    s_i = lo_c_r + prod_r[TW+FW-1:FW];
    s_c = neg_c_r ? (SIG_ONE - s_i) : s_i;
    s_w = SW'(s_c);
    if (FRAC_BITS > 16) begin
      s16_nxt = 17'((s_w + SW'(RND)) >> SH_R);
    end else begin
      s16_nxt = 17'(s_w << SH_L);
    end
  end

  always_ff @(posedge clk) begin
    s16_r   <= s16_nxt;
    tag_d_r <= tag_c_r;
  end

  assign sout.vld = vld_r[3];
  assign sout.s16 = s16_r;
  assign sout.tag = tag_d_r;

endmodule

// ===== test/tb_azimuth_sigmoid_gain.sv =====
// Self-checking testbench for azimuth_sigmoid_gain: azimuth words in bursts, predicted gains.
// Register settings go through the APB port between phases and are read back.
// Depends on asg_pkg and the azimuth_sigmoid_gain RTL.
module tb_azimuth_sigmoid_gain
  import asg_pkg::*;
();

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int PIPE_LATENCY    = 8;
  localparam int IDLE_LIMIT      = 2000;
  localparam int NUM_REGS        = 8;
  localparam int RANDOM_PHASES   = 9;
  localparam int WORDS_PER_PHASE = 215;

  // Fixed-point constants of the gain curve
  localparam int              ARG_Q      = 28;
  localparam longint unsigned ARG_UNIT   = 64'd1 << ARG_Q;
  localparam longint unsigned EXP_ONE    = 64'd1 << 31;
  localparam longint unsigned SIG_SPAN   = 16;
  localparam longint unsigned HALF_TURN  = 32768;
  localparam longint unsigned FULL_TURN  = 65536;
  localparam longint unsigned GAIN_UNITY = 65536;
  localparam longint unsigned GAIN_ROUND = 64'd1 << 15;

  // Register values after reset
  localparam logic [15:0] DEF_SLOPE_A     = 16'd7680;
  localparam logic [15:0] DEF_POSITION_A  = 16'd26214;
  localparam logic [15:0] DEF_FLOOR_A     = 16'd4588;
  localparam logic [23:0] DEF_INV_RANGE_A = 24'd71939;
  localparam logic [15:0] DEF_SLOPE_B     = 16'd3584;
  localparam logic [15:0] DEF_POSITION_B  = 16'd8520;
  localparam logic [15:0] DEF_FLOOR_B     = 16'd0;
  localparam logic [23:0] DEF_INV_RANGE_B = 24'd66265;

  typedef struct {
    logic [16:0] gain;
    logic        curve_b;
  } gain_word_t;

  // Predicts the gain of every accepted azimuth and checks results in order
  class gain_scoreboard;
    cfg_t            regs;
    longint unsigned sig_lut [SIG_DEPTH+1];
    gain_word_t      expected_q [$];
    int              errors;
    int              checked;
    int              curve_b_seen;
    int              saturated;
    int              floored;

    function new();
      longint unsigned term, sum, ratio, p, den, num;
      // Build e^(-16/depth) by series, then the logistic table from its powers
      term = EXP_ONE;
      sum  = EXP_ONE;
      for (int k = 1; k <= 24; k++) begin
        term = (term * SIG_SPAN) / (longint'(SIG_DEPTH) * k);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      ratio = sum;
      p     = EXP_ONE;
      num   = 64'd1 << (FRAC_BITS + 31);
      for (int i = 0; i <= SIG_DEPTH; i++) begin
        den        = EXP_ONE + p;
        sig_lut[i] = (num + den / 2) / den;
        p          = (p * ratio) >> 31;
      end
      regs.slope_a     = DEF_SLOPE_A;
      regs.position_a  = DEF_POSITION_A;
      regs.floor_a     = DEF_FLOOR_A;
      regs.inv_range_a = DEF_INV_RANGE_A;
      regs.slope_b     = DEF_SLOPE_B;
      regs.position_b  = DEF_POSITION_B;
      regs.floor_b     = DEF_FLOOR_B;
      regs.inv_range_b = DEF_INV_RANGE_B;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_SLOPE_A:     regs.slope_a     = v[15:0];
        REG_POSITION_A:  regs.position_a  = v[15:0];
        REG_FLOOR_A:     regs.floor_a     = v[15:0];
        REG_INV_RANGE_A: regs.inv_range_a = v[23:0];
        REG_SLOPE_B:     regs.slope_b     = v[15:0];
        REG_POSITION_B:  regs.position_b  = v[15:0];
        REG_FLOOR_B:     regs.floor_b     = v[15:0];
        REG_INV_RANGE_B: regs.inv_range_b = v[23:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_SLOPE_A:     return 32'(regs.slope_a);
        REG_POSITION_A:  return 32'(regs.position_a);
        REG_FLOOR_A:     return 32'(regs.floor_a);
        REG_INV_RANGE_A: return 32'(regs.inv_range_a);
        REG_SLOPE_B:     return 32'(regs.slope_b);
        REG_POSITION_B:  return 32'(regs.position_b);
        REG_FLOOR_B:     return 32'(regs.floor_b);
        default:         return 32'(regs.inv_range_b);
      endcase
    endfunction

    function void check_readback(logic [2:0] idx, logic [31:0] rdata);
      if (rdata !== reg_value(idx)) begin
        $display("%0t: register %0d readback mismatch, expected 'h%0h, actual 'h%0h",
                 $time, idx, reg_value(idx), rdata);
        errors++;
      end
    endfunction

    // Logistic of slope*(u-pos), Q1.16, from the table with linear interpolation
    function longint unsigned logistic_q16(longint unsigned slope, longint unsigned u,
                                           longint unsigned pos);
      longint unsigned mag, m, q, idx, frac, s, lo, hi;
      bit              below;
      int              sh;
      below = (u < pos);
      mag   = below ? pos - u : u - pos;
      m     = slope * mag;
      if (m > ARG_UNIT) begin
        m = ARG_UNIT;
      end
      q    = m * SIG_DEPTH;
      idx  = q >> ARG_Q;
      frac = q & (ARG_UNIT - 1);
      if (idx >= SIG_DEPTH) begin
        s = sig_lut[SIG_DEPTH];
      end else begin
        lo = sig_lut[idx];
        hi = sig_lut[idx + 1];
        s  = lo + (((hi - lo) * frac) >> ARG_Q);
      end
      if (below) begin
        s = (64'd1 << FRAC_BITS) - s;
      end
      sh = FRAC_BITS - 16;
      if (sh > 0) begin
        s = (s + (64'd1 << (sh - 1))) >> sh;
      end else begin
        s = s << (-sh);
      end
      return s;
    endfunction

    function void note_azimuth(logic [15:0] x);
      gain_word_t      w;
      longint unsigned slope, pos, flr, inv, u, s16, g;
      w.curve_b = (x >= HALF_TURN);
      if (w.curve_b) begin
        slope = regs.slope_b;
        pos   = regs.position_b;
        flr   = regs.floor_b;
        inv   = regs.inv_range_b;
        u     = FULL_TURN - x;
      end else begin
        slope = regs.slope_a;
        pos   = regs.position_a;
        flr   = regs.floor_a;
        inv   = regs.inv_range_a;
        u     = x;
      end
      s16 = logistic_q16(slope, u, pos);
      // Clamp at or below the floor to zero and above unity to one
      if (s16 <= flr) begin
        g = 0;
      end else begin
        g = ((s16 - flr) * inv + GAIN_ROUND) >> 16;
        if (g > GAIN_UNITY) begin
          g = GAIN_UNITY;
        end
      end
      w.gain = 17'(g);
      if (g == 0) floored++;
      if (g == GAIN_UNITY) saturated++;
      if (w.curve_b) curve_b_seen++;
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [16:0] gain, logic curve_b);
      gain_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no word pending, gain %0d curve_b %0d",
                 $time, gain, curve_b);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      checked++;
      if (gain !== w.gain) begin
        $display("%0t: gain mismatch, expected %0d, actual %0d", $time, w.gain, gain);
        errors++;
      end
      if (curve_b !== w.curve_b) begin
        $display("%0t: used_curve_b mismatch, expected %0d, actual %0d",
                 $time, w.curve_b, curve_b);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [15:0]       in_azimuth_turn;
  logic              out_valid;
  logic [16:0]       out_gain;
  logic              out_used_curve_b;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  gain_scoreboard sb;
  int             idle_cycles;
  int             settings_loaded;

  azimuth_sigmoid_gain i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_azimuth_turn  (in_azimuth_turn),
    .out_valid        (out_valid),
    .out_gain         (out_gain),
    .out_used_curve_b (out_used_curve_b),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Note accepted words and check results at the edge that takes them
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_azimuth(in_azimuth_turn);
      end
      if (out_valid) begin
        sb.check_result(out_gain, out_used_curve_b);
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic check_reg(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(32'(idx) * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_readback(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one register with junk above its width, then read it back
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    if (idx == REG_INV_RANGE_A || idx == REG_INV_RANGE_B) begin
      wdata[23:0] = value;
    end else begin
      wdata[15:0] = value[15:0];
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(32'(idx) * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic load_settings(input logic [15:0] s_a, input logic [15:0] p_a,
                               input logic [15:0] f_a, input logic [23:0] i_a,
                               input logic [15:0] s_b, input logic [15:0] p_b,
                               input logic [15:0] f_b, input logic [23:0] i_b);
    write_reg(REG_SLOPE_A, 24'(s_a));
    write_reg(REG_POSITION_A, 24'(p_a));
    write_reg(REG_FLOOR_A, 24'(f_a));
    write_reg(REG_INV_RANGE_A, i_a);
    write_reg(REG_SLOPE_B, 24'(s_b));
    write_reg(REG_POSITION_B, 24'(p_b));
    write_reg(REG_FLOOR_B, 24'(f_b));
    write_reg(REG_INV_RANGE_B, i_b);
    settings_loaded++;
  endtask

  // Pick curve settings that mostly keep the curve interesting, sometimes extreme
  task automatic shuffle_curves();
    logic [15:0] slope [2];
    logic [15:0] pos [2];
    logic [15:0] flr [2];
    logic [23:0] inv [2];
    for (int c = 0; c < 2; c++) begin
      case ($urandom_range(0, 7))
        0:       slope[c] = 16'h0000;
        1:       slope[c] = 16'hFFFF;
        2:       slope[c] = 16'($urandom_range(0, 16'hFFFF));
        default: slope[c] = 16'($urandom_range(16'h0100, 16'h2800));
      endcase
      pos[c] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                           : 16'($urandom_range(0, 32'(HALF_TURN)));
      case ($urandom_range(0, 5))
        0:       flr[c] = 16'h0000;
        1:       flr[c] = 16'($urandom_range(0, 16'hFFFF));
        default: flr[c] = 16'($urandom_range(0, 8000));
      endcase
      case ($urandom_range(0, 5))
        0:       inv[c] = 24'($urandom_range(0, 24'hFFFFFF));
        1:       inv[c] = 24'hFFFFFF;
        default: inv[c] = 24'($urandom_range(60000, 140000));
      endcase
    end
    load_settings(slope[0], pos[0], flr[0], inv[0], slope[1], pos[1], flr[1], inv[1]);
  endtask

  // Mostly uniform azimuths, with a share aimed at each curve's midpoint and the corners
  function automatic logic [15:0] pick_azimuth();
    int v;
    case ($urandom_range(0, 9))
      5, 6: begin
        v = int'(sb.regs.position_a) + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > int'(HALF_TURN) - 1) v = int'(HALF_TURN) - 1;
        return 16'(v);
      end
      7, 8: begin
        v = int'(sb.regs.position_b) + int'($urandom_range(0, 128)) - 64;
        if (v < 1) v = 1;
        if (v > int'(HALF_TURN)) v = int'(HALF_TURN);
        return 16'(int'(FULL_TURN) - v);
      end
      9: begin
        case ($urandom_range(0, 5))
          0:       return 16'h0000;
          1:       return 16'h7FFF;
          2:       return 16'h8000;
          3:       return 16'hFFFF;
          4:       return 16'(int'(HALF_TURN) - 1 - int'($urandom_range(0, 15)));
          default: return 16'(int'(HALF_TURN) + int'($urandom_range(0, 15)));
        endcase
      end
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_word(input logic [15:0] x);
    start           <= 1'b1;
    in_azimuth_turn <= x;
    do @(posedge clk); while (busy);
  endtask

  // Wait until every predicted word has come out, then wait out the given tail
  task automatic drain(input int tail);
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  // Send words in bursts; gaps vary from none to long, sometimes until empty
  task automatic run_bursts(input int count);
    int left, burst, mode;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_word(pick_azimuth());
      left -= burst;
      mode = $urandom_range(0, 19);
      if (mode >= 6 || left == 0) begin
        start           <= 1'b0;
        in_azimuth_turn <= 16'($urandom());
        if (mode == 19) begin
          drain(0);
        end else if (mode < 9) begin
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    static logic [15:0] corners_default [15] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                                16'h8001, 16'hFFFF, 16'd26214, 16'd26213,
                                                16'd26215, 16'd57016, 16'd57017, 16'h5555,
                                                16'hAAAA, 16'h0F0F, 16'hF0F0};
    static logic [15:0] corners_flat [5]  = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                              16'hFFFF};
    static logic [15:0] corners_steep [5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                              16'h1234};
    sb              = new();
    settings_loaded = 0;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_azimuth_turn <= 16'h0000;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, then corners of the default curves
    for (int r = 0; r < NUM_REGS; r++) begin
      check_reg(3'(r));
    end
    foreach (corners_default[i]) send_word(corners_default[i]);
    start <= 1'b0;
    drain(2);

    // Zero slope gives one half everywhere; huge range saturates, floor at one half clamps
    load_settings(16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF,
                  16'h0000, 16'hFFFF, 16'h8000, 24'hFFFFFF);
    foreach (corners_flat[i]) send_word(corners_flat[i]);
    start <= 1'b0;
    drain(2);

    // Steepest slope: clipped argument, floor at maximum, zero reciprocal range
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h000000,
                  16'hFFFF, 16'h0000, 16'h0000, 24'h010000);
    foreach (corners_steep[i]) send_word(corners_steep[i]);
    start <= 1'b0;
    drain(2);

    // Random curve settings with random bursts of words
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      shuffle_curves();
      run_bursts(WORDS_PER_PHASE);
      drain(2);
    end

    drain(PIPE_LATENCY + 4);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected gain words never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    $display("Checked %0d gain words over %0d register settings:", sb.checked,
             settings_loaded + 1);
    $display("  %0d on curve B, %0d saturated at unity, %0d clamped to zero.",
             sb.curve_b_seen, sb.saturated, sb.floored);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/asg_pkg.sv
hdl/asg_regs.sv
hdl/asg_sigmoid.sv
hdl/azimuth_sigmoid_gain.sv
test/tb_azimuth_sigmoid_gain.sv
